// File: src/pcad_pkg.sv
// ----------------------------------------------------------------------------
// Pixel charge accumulate and digitize: shared definitions
// Constants, item and result types, and helper functions of the block.
// ----------------------------------------------------------------------------
package pcad_pkg;

   localparam int COLS     = 128;
   localparam int ROWS     = 128;
   localparam int MAX_HITS = 256;

   localparam int NPIX     = COLS * ROWS;
   localparam int PIX_AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
   localparam int LIST_AW  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int HIT_W    = $clog2(MAX_HITS + 1);
   localparam int LIST_W   = 20;
   localparam int PIX_W    = 57;

   localparam logic [23:0] MASK24 = 24'hFFFFFF;

   localparam int TDC_MAX   = 32;
   localparam int TDC_DIV   = 10;
   localparam int TDC_LIMIT = TDC_DIV * (TDC_MAX + 1);
   localparam int TDC_RECIP = 205;
   localparam int TDC_SHIFT = 11;

   localparam int ADC_BITS_MAX = 12;

   typedef enum logic {
      OP_ACCUMULATE = 1'b0,
      OP_READ       = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      REG_THRESHOLD  = 2'd0,
      REG_FULL_RANGE = 2'd1,
      REG_ADC_BITS   = 2'd2
   } reg_index_type;

   typedef struct packed {
      opcode_type         opcode;
      logic               in_range;
      logic [PIX_AW-1:0]  addr;
      logic [9:0]         col;
      logic [9:0]         row;
      logic [23:0]        charge_e;
      logic [15:0]        hit_time;
      logic [15:0]        track_id;
      logic signed [15:0] noise_e;
   } item_type;

   typedef struct packed {
      logic [9:0]  out_col;
      logic [9:0]  out_row;
      logic [15:0] out_track;
      logic [23:0] noisy_charge;
      logic [23:0] adc_value;
      logic [5:0]  tdc_value;
      logic        fired;
      logic        last;
      logic        empty_res;
      logic        overflow;
   } result_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ACC_UPD,
      ST_RD_LIST,
      ST_RD_PIX,
      ST_RD_CALC,
      ST_DIV,
      ST_MUL,
      ST_SHIFT,
      ST_FIN,
      ST_CLR_RD,
      ST_CLR_WR
   } back_state_type;

   function automatic logic [PIX_AW-1:0] pix_addr(input logic [9:0] col,
                                                  input logic [9:0] row);
      pix_addr = PIX_AW'(int'(row) * COLS + int'(col));
   endfunction

endpackage

// File: src/pcad_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// File: src/pcad_front.sv
// ----------------------------------------------------------------------------
// Pixel charge accumulate and digitize: front end
// Accepts items, checks the pixel address and queues them for the back end.
// ----------------------------------------------------------------------------
module pcad_front
   import pcad_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  logic            in_opcode,
   input  logic [9:0]      in_col,
   input  logic [9:0]      in_row,
   input  logic [23:0]     in_charge_e,
   input  logic [15:0]     in_hit_time,
   input  logic [15:0]     in_track_id,
   input  logic [15:0]     in_noise_e,
   input  back_status_type status,
   output logic            q_valid,
   output item_type        q_item,
   input  logic            q_pop
);

   item_type   slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item;
   logic       do_push, do_pop;

   always_comb begin
      item.opcode   = opcode_type'(in_opcode);
      item.in_range = (int'(in_col) < COLS) && (int'(in_row) < ROWS);
      item.addr     = pix_addr(in_col, in_row);
      item.col      = in_col;
      item.row      = in_row;
      item.charge_e = in_charge_e;
      item.hit_time = in_hit_time;
      item.track_id = in_track_id;
      item.noise_e  = $signed(in_noise_e);
   end

   assign full    = (count_ff == 2'd2) || status.init_busy;
   assign do_push = push && !full;
   assign q_valid = (count_ff != 2'd0);
   assign do_pop  = q_pop && q_valid;
   assign q_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: src/pcad_back.sv
// ----------------------------------------------------------------------------
// Pixel charge accumulate and digitize: back end
// Sequencer for pixel store updates, readout, digitization and store clearing.
// ----------------------------------------------------------------------------
module pcad_back
   import pcad_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [15:0]     threshold_e,
   input  logic [23:0]     full_range_e,
   input  logic [3:0]      adc_bits,
   input  logic            q_valid,
   input  item_type        q_item,
   output logic            q_pop,
   output back_status_type status,
   output logic            res_valid,
   output result_type      res,
   input  logic            res_pop
);

   back_state_type state_ff, state_in;
   logic [PIX_AW-1:0]  init_cnt_ff, init_cnt_in;
   logic [HIT_W-1:0]   hit_count_ff, hit_count_in;
   logic [HIT_W-1:0]   rp_ff, rp_in;
   logic [HIT_W-1:0]   ci_ff, ci_in;
   logic               ovf_ff, ovf_in;
   logic               res_valid_ff, res_valid_in;
   result_type         res_ff, res_in;
   item_type           cur_ff, cur_in;
   logic [23:0]        noisy_ff, noisy_in;
   logic [15:0]        time_ff, time_in;
   logic [15:0]        track_ff, track_in;
   logic [24:0]        rem_ff, rem_in;
   logic [11:0]        steps_ff, steps_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [35:0]        prod_ff, prod_in;
   logic [23:0]        adc_ff, adc_in;
   logic [5:0]         tdc_ff, tdc_in;
   logic               fired_ff, fired_in;
   logic               empty_ff, empty_in;

   logic               pix_we, list_we;
   logic [PIX_AW-1:0]  pix_waddr, pix_raddr;
   logic [PIX_W-1:0]   pix_wdata, pix_rdata;
   logic [LIST_AW-1:0] list_waddr, list_raddr;
   logic [LIST_W-1:0]  list_wdata, list_rdata;

   logic [24:0]        sum;
   logic signed [25:0] noisy_s;
   logic [23:0]        span, diff;
   logic [3:0]         bits;
   logic [24:0]        rem2;
   logic [8:0]         t9;
   logic [16:0]        tprod;
   logic [35:0]        shifted;

   pcad_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_pix_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (pix_waddr),
      .wdata (pix_wdata),
      .raddr (pix_raddr),
      .rdata (pix_rdata)
   );

   pcad_ram #(.WIDTH(LIST_W), .DEPTH(MAX_HITS)) u_list_ram (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (list_wdata),
      .raddr (list_raddr),
      .rdata (list_rdata)
   );

   assign status.init_busy = (state_ff == ST_INIT);
   assign res_valid        = res_valid_ff;
   assign res              = res_ff;

   always_comb begin
      if (adc_bits == 4'd0) begin
         bits = 4'd1;
      end else if (int'(adc_bits) > ADC_BITS_MAX) begin
         bits = 4'(ADC_BITS_MAX);
      end else begin
         bits = adc_bits;
      end
   end

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      hit_count_in = hit_count_ff;
      rp_in        = rp_ff;
      ci_in        = ci_ff;
      ovf_in       = ovf_ff;
      res_valid_in = res_valid_ff && !res_pop;
      res_in       = res_ff;
      cur_in       = cur_ff;
      noisy_in     = noisy_ff;
      time_in      = time_ff;
      track_in     = track_ff;
      rem_in       = rem_ff;
      steps_in     = steps_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      adc_in       = adc_ff;
      tdc_in       = tdc_ff;
      fired_in     = fired_ff;
      empty_in     = empty_ff;
      q_pop        = 1'b0;
      pix_we       = 1'b0;
      pix_waddr    = cur_ff.addr;
      pix_wdata    = '0;
      pix_raddr    = q_item.addr;
      list_we      = 1'b0;
      list_waddr   = hit_count_ff[LIST_AW-1:0];
      list_wdata   = {cur_ff.row, cur_ff.col};
      list_raddr   = rp_ff[LIST_AW-1:0];
      sum          = {1'b0, pix_rdata[55:32]} + {1'b0, cur_ff.charge_e};
      noisy_s      = $signed({2'b00, pix_rdata[55:32]}) + 26'(cur_ff.noise_e);
      span         = full_range_e - {8'd0, threshold_e};
      diff         = noisy_ff - {8'd0, threshold_e};
      rem2         = {rem_ff[23:0], 1'b0};
      t9           = time_ff[8:0];
      tprod        = 17'(t9) * 17'(TDC_RECIP);
      shifted      = prod_ff >> bits;

      case (state_ff)
         ST_INIT: begin
            pix_we      = 1'b1;
            pix_waddr   = init_cnt_ff;
            pix_wdata   = '0;
            init_cnt_in = init_cnt_ff + 1'b1;
            if (int'(init_cnt_ff) == NPIX - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               if (q_item.opcode == OP_ACCUMULATE) begin
                  if (q_item.in_range) begin
                     state_in = ST_ACC_UPD;
                  end
               end else if (rp_ff >= hit_count_ff) begin
                  empty_in = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  empty_in = 1'b0;
                  state_in = ST_RD_LIST;
               end
            end
         end
         ST_ACC_UPD: begin
            state_in = ST_IDLE;
            if (pix_rdata[56]) begin
               pix_we    = 1'b1;
               pix_wdata = pix_rdata;
               pix_wdata[55:32] = sum[24] ? MASK24 : sum[23:0];
               if (cur_ff.hit_time < pix_rdata[31:16]) begin
                  pix_wdata[31:16] = cur_ff.hit_time;
               end
            end else if (int'(hit_count_ff) >= MAX_HITS) begin
               ovf_in = 1'b1;
            end else begin
               pix_we       = 1'b1;
               pix_wdata    = {1'b1, cur_ff.charge_e, cur_ff.hit_time, cur_ff.track_id};
               list_we      = 1'b1;
               hit_count_in = hit_count_ff + 1'b1;
            end
         end
         ST_RD_LIST: begin
            cur_in.col = list_rdata[9:0];
            cur_in.row = list_rdata[19:10];
            pix_raddr  = pix_addr(list_rdata[9:0], list_rdata[19:10]);
            rp_in      = rp_ff + 1'b1;
            state_in   = ST_RD_PIX;
         end
         ST_RD_PIX: begin
            if (noisy_s < 0) begin
               noisy_in = '0;
            end else if (noisy_s > $signed({2'b00, MASK24})) begin
               noisy_in = MASK24;
            end else begin
               noisy_in = noisy_s[23:0];
            end
            time_in  = pix_rdata[31:16];
            track_in = pix_rdata[15:0];
            state_in = ST_RD_CALC;
         end
         ST_RD_CALC: begin
            fired_in = noisy_ff > {8'd0, threshold_e};
            if (int'(time_ff) >= TDC_LIMIT) begin
               tdc_in = 6'(TDC_MAX);
            end else begin
               tdc_in = tprod[16:11];
            end
            if ((noisy_ff > {8'd0, threshold_e}) && (full_range_e > {8'd0, threshold_e})) begin
               if (diff >= span) begin
                  steps_in = 12'((13'd1 << bits) - 13'd1);
                  state_in = ST_MUL;
               end else begin
                  rem_in   = {1'b0, diff};
                  steps_in = '0;
                  cnt_in   = bits;
                  state_in = ST_DIV;
               end
            end else begin
               adc_in   = {8'd0, threshold_e};
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            if (rem2 >= {1'b0, span}) begin
               rem_in   = rem2 - {1'b0, span};
               steps_in = {steps_ff[10:0], 1'b1};
            end else begin
               rem_in   = rem2;
               steps_in = {steps_ff[10:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 4'd1) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 36'(steps_ff) * 36'(span);
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            adc_in   = {8'd0, threshold_e} + shifted[23:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!res_valid_ff || res_pop) begin
               res_valid_in = 1'b1;
               res_in       = '0;
               if (empty_ff) begin
                  res_in.empty_res = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  res_in.out_col      = cur_ff.col;
                  res_in.out_row      = cur_ff.row;
                  res_in.out_track    = track_ff;
                  res_in.noisy_charge = noisy_ff;
                  res_in.adc_value    = adc_ff;
                  res_in.tdc_value    = tdc_ff;
                  res_in.fired        = fired_ff;
                  res_in.last         = rp_ff >= hit_count_ff;
                  res_in.overflow     = ovf_ff;
                  if (rp_ff >= hit_count_ff) begin
                     ci_in    = '0;
                     state_in = ST_CLR_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_CLR_RD: begin
            list_raddr = ci_ff[LIST_AW-1:0];
            state_in   = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            pix_we    = 1'b1;
            pix_waddr = pix_addr(list_rdata[9:0], list_rdata[19:10]);
            pix_wdata = '0;
            ci_in     = ci_ff + 1'b1;
            if (ci_ff + 1'b1 >= hit_count_ff) begin
               hit_count_in = '0;
               rp_in        = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_CLR_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         hit_count_ff <= '0;
         rp_ff        <= '0;
         ci_ff        <= '0;
         ovf_ff       <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         hit_count_ff <= hit_count_in;
         rp_ff        <= rp_in;
         ci_ff        <= ci_in;
         ovf_ff       <= ovf_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      cur_ff   <= cur_in;
      noisy_ff <= noisy_in;
      time_ff  <= time_in;
      track_ff <= track_in;
      rem_ff   <= rem_in;
      steps_ff <= steps_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      adc_ff   <= adc_in;
      tdc_ff   <= tdc_in;
      fired_ff <= fired_in;
      empty_ff <= empty_in;
   end

   a_hit_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(hit_count_ff) <= MAX_HITS)
      else $error("hit count above list depth");

   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= hit_count_ff)
      else $error("read pointer beyond hit count");

   a_no_result_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !res_valid_ff)
      else $error("result during clearing pass");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff != 4'd0))
      else $error("divider step count exhausted");

endmodule

// File: src/pixel_charge_accumulate_digitize.sv
// ----------------------------------------------------------------------------
// Pixel charge accumulate and digitize
// Per-pixel charge store with threshold readout, ADC and TDC digitization.
// ----------------------------------------------------------------------------
// Items enter through a queue interface (push/full). An accumulate word adds
// charge to one pixel and causes no result; a read word pops the next listed
// pixel and causes exactly one result word on the rsp side (empty/pop).
// Results stay on the rsp ports until popped; while a result waits, further
// accumulate words are still processed and two more words can be queued.
// An accumulate word is a pixel RAM read-modify-write in the back end. A read
// word goes through list and pixel RAM reads, then one serial divider step per
// ADC bit, plus a multiply. Popping the last listed pixel starts a clearing
// sweep of one list RAM read and one pixel RAM write per listed pixel. After
// reset, full stays high while all 16384 pixel RAM words are cleared;
// configuration writes are taken at any time.
// Registers: threshold_e at 0x0, full_range_e at 0x4, adc_bits at 0x8.
// ----------------------------------------------------------------------------
module pixel_charge_accumulate_digitize
   import pcad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_opcode,
   input  logic [9:0]  req_col,
   input  logic [9:0]  req_row,
   input  logic [23:0] req_charge_e,
   input  logic [15:0] req_hit_time,
   input  logic [15:0] req_track_id,
   input  logic [15:0] req_noise_e,
   output logic        empty,
   input  logic        pop,
   output logic [9:0]  rsp_out_col,
   output logic [9:0]  rsp_out_row,
   output logic [15:0] rsp_out_track,
   output logic [23:0] rsp_noisy_charge,
   output logic [23:0] rsp_adc_value,
   output logic [5:0]  rsp_tdc_value,
   output logic        rsp_fired,
   output logic        rsp_last,
   output logic        rsp_empty_res,
   output logic        rsp_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0]     threshold_ff;
   logic [23:0]     full_range_ff;
   logic [3:0]      adc_bits_ff;
   logic            cfg_we;
   reg_index_type   cfg_idx;
   back_status_type status;
   logic            q_valid, q_pop;
   item_type        q_item;
   logic            res_valid;
   result_type      res;

   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite;
   assign cfg_idx = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= 16'd100;
         full_range_ff <= 24'd4096;
         adc_bits_ff   <= 4'd8;
      end else if (cfg_we) begin
         case (cfg_idx)
            REG_THRESHOLD:  threshold_ff  <= pwdata[15:0];
            REG_FULL_RANGE: full_range_ff <= pwdata[23:0];
            REG_ADC_BITS:   adc_bits_ff   <= pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_THRESHOLD:  prdata = {16'd0, threshold_ff};
         REG_FULL_RANGE: prdata = {8'd0, full_range_ff};
         REG_ADC_BITS:   prdata = {28'd0, adc_bits_ff};
         default:        prdata = '0;
      endcase
   end

   pcad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .in_opcode   (req_opcode),
      .in_col      (req_col),
      .in_row      (req_row),
      .in_charge_e (req_charge_e),
      .in_hit_time (req_hit_time),
      .in_track_id (req_track_id),
      .in_noise_e  (req_noise_e),
      .status      (status),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   pcad_back u_back (
      .clock        (clock),
      .reset        (reset),
      .threshold_e  (threshold_ff),
      .full_range_e (full_range_ff),
      .adc_bits     (adc_bits_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .status       (status),
      .res_valid    (res_valid),
      .res          (res),
      .res_pop      (pop)
   );

   assign empty            = !res_valid;
   assign rsp_out_col      = res.out_col;
   assign rsp_out_row      = res.out_row;
   assign rsp_out_track    = res.out_track;
   assign rsp_noisy_charge = res.noisy_charge;
   assign rsp_adc_value    = res.adc_value;
   assign rsp_tdc_value    = res.tdc_value;
   assign rsp_fired        = res.fired;
   assign rsp_last         = res.last;
   assign rsp_empty_res    = res.empty_res;
   assign rsp_overflow     = res.overflow;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Pixel charge accumulate and digitize: testbench
// Drives accumulate and read words through the queue interface and writes the
// registers between phases. A behavioral copy of the pixel store predicts each
// readout word, and every popped word is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
   import pcad_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_opcode = 1'b0;
   logic [9:0]  req_col = '0;
   logic [9:0]  req_row = '0;
   logic [23:0] req_charge_e = '0;
   logic [15:0] req_hit_time = '0;
   logic [15:0] req_track_id = '0;
   logic [15:0] req_noise_e = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [9:0]  rsp_out_col;
   logic [9:0]  rsp_out_row;
   logic [15:0] rsp_out_track;
   logic [23:0] rsp_noisy_charge;
   logic [23:0] rsp_adc_value;
   logic [5:0]  rsp_tdc_value;
   logic        rsp_fired;
   logic        rsp_last;
   logic        rsp_empty_res;
   logic        rsp_overflow;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   pixel_charge_accumulate_digitize i_dut (.*);

   always #6 clock = ~clock;

   // Behavioral pixel store.
   logic [23:0] pix_charge [NPIX];
   logic [15:0] pix_time [NPIX];
   logic [15:0] pix_track [NPIX];
   bit          pix_listed [NPIX];
   int          hit_order[$];
   int          read_pos;
   bit          dropped;
   int          thr_e;
   int          range_e;
   int          bits_cfg;

   result_type  readout_q[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;
   int          pop_hold = 0;

   function automatic int draw_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   function automatic void deposit(logic [9:0] c, logic [9:0] r, logic [23:0] q,
                                   logic [15:0] t, logic [15:0] trk);
      int idx;
      longint sum;
      if (c >= COLS || r >= ROWS) return;
      idx = int'(r) * COLS + int'(c);
      if (pix_listed[idx]) begin
         sum = longint'(pix_charge[idx]) + longint'(q);
         pix_charge[idx] = (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
         if (t < pix_time[idx]) pix_time[idx] = t;
         return;
      end
      if (hit_order.size() >= MAX_HITS) begin
         dropped = 1'b1;
         return;
      end
      pix_listed[idx] = 1'b1;
      pix_charge[idx] = q;
      pix_time[idx] = t;
      pix_track[idx] = trk;
      hit_order.insert(hit_order.size(), idx);
   endfunction

   function automatic result_type digitize(logic [15:0] noise);
      result_type res;
      int idx;
      int nb;
      longint nz;
      longint span;
      longint steps;
      longint adc;
      int tdc;
      res = '0;
      if (read_pos >= hit_order.size()) begin
         res.empty_res = 1'b1;
         return res;
      end
      idx = hit_order[read_pos];
      read_pos++;
      nz = longint'(pix_charge[idx]) + longint'($signed(noise));
      if (nz < 0) nz = 0;
      if (nz > 24'hFFFFFF) nz = 24'hFFFFFF;
      nb = (bits_cfg == 0) ? 1 : ((bits_cfg > ADC_BITS_MAX) ? ADC_BITS_MAX : bits_cfg);
      adc = thr_e;
      res.fired = (nz > thr_e);
      if (res.fired && range_e > thr_e) begin
         span = range_e - thr_e;
         steps = ((nz - thr_e) << nb) / span;
         if (steps >= (longint'(1) << nb)) steps = (longint'(1) << nb) - 1;
         adc = thr_e + ((steps * span) >> nb);
      end
      tdc = int'(pix_time[idx]) / 10;
      if (tdc > TDC_MAX) tdc = TDC_MAX;
      res.out_col = 10'(idx % COLS);
      res.out_row = 10'(idx / COLS);
      res.out_track = pix_track[idx];
      res.noisy_charge = nz[23:0];
      res.adc_value = adc[23:0];
      res.tdc_value = tdc[5:0];
      res.last = (read_pos >= hit_order.size());
      res.overflow = dropped;
      if (res.last) begin
         foreach (hit_order[i]) pix_listed[hit_order[i]] = 1'b0;
         hit_order.delete();
         read_pos = 0;
         dropped = 1'b0;
      end
      return res;
   endfunction

   // Called and returning at a falling edge.
   task automatic send_word(opcode_type op, logic [9:0] c, logic [9:0] r,
                            logic [23:0] q, logic [15:0] t, logic [15:0] trk,
                            logic [15:0] noise);
      int g;
      g = draw_gap();
      if (g > 0) begin
         push <= 1'b0;
         repeat (g) @(negedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_col <= c;
      req_row <= r;
      req_charge_e <= q;
      req_hit_time <= t;
      req_track_id <= trk;
      req_noise_e <= noise;
      @(posedge clock);
      while (full) @(posedge clock);
      if (op == OP_ACCUMULATE) deposit(c, r, q, t, trk);
      else readout_q.insert(readout_q.size(), digitize(noise));
      @(negedge clock);
   endtask

   task automatic send_acc(logic [9:0] c, logic [9:0] r, logic [23:0] q,
                           logic [15:0] t, logic [15:0] trk);
      send_word(OP_ACCUMULATE, c, r, q, t, trk, 16'($urandom));
   endtask

   task automatic send_read(logic [15:0] noise);
      send_word(OP_READ, 10'($urandom), 10'($urandom), 24'($urandom), 16'($urandom),
                16'($urandom), noise);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (readout_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type reg_idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_idx)
         REG_THRESHOLD:  thr_e = value[15:0];
         REG_FULL_RANGE: range_e = value[23:0];
         default:        bits_cfg = value[3:0];
      endcase
   endtask

   task automatic set_adc(int thr, int fr, int nb);
      drain();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_FULL_RANGE, fr);
      write_reg(REG_ADC_BITS, nb);
   endtask

   task automatic test_reset_settings();
      send_acc(10'd0, 10'd0, 24'd0, 16'd0, 16'd0);
      send_acc(10'd127, 10'd127, 24'd5000, 16'hFFFF, 16'hFFFF);
      send_read(16'sd0);
      send_read(16'h8000);
   endtask

   task automatic test_address_range();
      send_acc(10'd128, 10'd5, 24'd777, 16'd3, 16'd1);
      send_acc(10'd5, 10'd128, 24'd777, 16'd3, 16'd1);
      send_acc(10'h3FF, 10'h3FF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      send_acc(10'd3, 10'd4, 24'd1234, 16'd321, 16'd42);
      send_read(16'h7FFF);
      send_read(16'd0);
   endtask

   task automatic test_saturation();
      send_acc(10'd9, 10'd1, 24'hFFFFF0, 16'd500, 16'd7);
      send_acc(10'd9, 10'd1, 24'hFFFFFF, 16'd20, 16'd8);
      send_acc(10'd9, 10'd1, 24'd1, 16'd900, 16'd9);
      send_read(16'h7FFF);
   endtask

   task automatic test_adc_extremes();
      set_adc(0, 24'hFFFFFF, 12);
      send_acc(10'd1, 10'd2, 24'hFFFFFF, 16'd329, 16'd1);
      send_acc(10'd2, 10'd2, 24'd1, 16'd330, 16'd2);
      send_read(16'd0);
      send_read(16'hFFFF);
      set_adc(65535, 100, 0);
      send_acc(10'd1, 10'd2, 24'hFFFFFF, 16'd9, 16'd1);
      send_read(16'h8000);
      set_adc(50, 1000, 15);
      send_acc(10'd4, 10'd4, 24'd51, 16'd10, 16'd3);
      send_acc(10'd5, 10'd4, 24'd50, 16'd11, 16'd4);
      send_read(16'd0);
      send_read(16'd0);
   endtask

   task automatic test_overflow();
      set_adc(100, 4096, 8);
      for (int i = 0; i < MAX_HITS + 4; i++)
         send_acc(10'(i % COLS), 10'(i / COLS), 24'($urandom_range(0, 8000)),
                  16'($urandom), 16'($urandom));
      for (int i = 0; i < MAX_HITS; i++) send_read(16'($urandom));
      send_read(16'($urandom));
   endtask

   task automatic test_random();
      int n;
      int reads;
      int span_c;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_adc($urandom_range(0, 400), $urandom_range(1000, 20000), 8);
            1: set_adc(65535, 24'hFFFFFF, 1);
            2: set_adc(0, 0, 12);
            default: set_adc($urandom_range(0, 65535), $urandom & 24'hFFFFFF,
                             $urandom_range(0, 15));
         endcase
         calm = (phase == 2);
         for (int s = 0; s < 15; s++) begin
            n = $urandom_range(1, 12);
            span_c = ($urandom_range(0, 3) == 0) ? 127 : 7;
            reads = 0;
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0)
                  send_acc(10'($urandom), 10'($urandom), 24'($urandom), 16'($urandom),
                           16'($urandom));
               else
                  send_acc(10'($urandom_range(0, span_c)), 10'($urandom_range(0, span_c)),
                           24'(($urandom_range(0, 4) == 0) ? $urandom
                                                           : $urandom_range(0, 6000)),
                           16'(($urandom_range(0, 1) == 0) ? $urandom
                                                           : $urandom_range(0, 400)),
                           16'($urandom));
               if ($urandom_range(0, 5) == 0) begin
                  send_read(16'($urandom));
                  reads++;
               end
            end
            for (int k = reads; k < n + $urandom_range(0, 1); k++) send_read(16'($urandom));
         end
         if (phase == 3) drain();
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      result_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && pop && !empty) begin
         if (readout_q.size() == 0) begin
            report("unexpected word", 1, 0);
         end else begin
            want = readout_q.pop_front();
            if (rsp_out_col !== want.out_col) report("out_col", rsp_out_col, want.out_col);
            if (rsp_out_row !== want.out_row) report("out_row", rsp_out_row, want.out_row);
            if (rsp_out_track !== want.out_track)
               report("out_track", rsp_out_track, want.out_track);
            if (rsp_noisy_charge !== want.noisy_charge)
               report("noisy_charge", rsp_noisy_charge, want.noisy_charge);
            if (rsp_adc_value !== want.adc_value)
               report("adc_value", rsp_adc_value, want.adc_value);
            if (rsp_tdc_value !== want.tdc_value)
               report("tdc_value", rsp_tdc_value, want.tdc_value);
            if (rsp_fired !== want.fired) report("fired", rsp_fired, want.fired);
            if (rsp_last !== want.last) report("last", rsp_last, want.last);
            if (rsp_empty_res !== want.empty_res)
               report("empty_res", rsp_empty_res, want.empty_res);
            if (rsp_overflow !== want.overflow)
               report("overflow", rsp_overflow, want.overflow);
         end
      end
   end

   always @(negedge clock) begin
      if (pop_hold > 0) begin
         pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         pop <= 1'b1;
         pop_hold <= draw_gap();
      end
   end

   initial begin
      thr_e = 100;
      range_e = 4096;
      bits_cfg = 8;
      read_pos = 0;
      dropped = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_address_range();
      test_saturation();
      test_adc_extremes();
      test_overflow();
      test_random();
      drain();
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
src/pcad_pkg.sv
src/pcad_ram.sv
src/pcad_front.sv
src/pcad_back.sv
src/pixel_charge_accumulate_digitize.sv
bench/tb_top.sv
